### rtl/cyrlcd_pkg.sv
// cyrlcd_pkg: shared types, constants and the character rom lookup
// for the cyrillic text transcoder; no dependencies
package cyrlcd_pkg;

   localparam logic [7:0] LEAD_BYTE_D0   = 8'hD0;
   localparam logic [7:0] LEAD_BYTE_D1   = 8'hD1;
   localparam logic [7:0] D0_YO_IN       = 8'h81;
   localparam logic [7:0] CP_YO_UPPER    = 8'hA8;
   localparam logic [7:0] D1_YO_IN       = 8'h91;
   localparam logic [7:0] CP_YO_LOWER    = 8'hB8;
   localparam logic [7:0] D0_OFFSET      = 8'h30;
   localparam logic [7:0] D1_OFFSET      = 8'h70;
   localparam logic [7:0] CP_CYR_BASE    = 8'hC0;
   localparam logic [7:0] ROM_YO_UPPER   = 8'hA2;
   localparam logic [7:0] ROM_YO_LOWER   = 8'hB5;

   localparam int unsigned ROM_DEPTH = 64;

   typedef enum logic [1:0] {
      LEAD_NONE = 2'd0,
      LEAD_D0   = 2'd1,
      LEAD_D1   = 2'd2
   } lead_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] display_code;
      logic       last_code;
   } rsp_payload_type;

   typedef struct packed {
      logic utf8_mode;
   } csr_payload_type;

   typedef logic [7:0] rom_array_type [ROM_DEPTH];

   // rom codes for cp1251 bytes 0xc0..0xff
   localparam rom_array_type CYR_ROM = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   function automatic logic [7:0] to_rom(input logic [7:0] c);
      logic [7:0] code;
      code = c;
      if (c >= CP_CYR_BASE) begin
         code = CYR_ROM[c[5:0]];
      end else if (c == CP_YO_UPPER) begin
         code = ROM_YO_UPPER;
      end else if (c == CP_YO_LOWER) begin
         code = ROM_YO_LOWER;
      end
      return code;
   endfunction

   function automatic logic [7:0] fold_second(input lead_type lead, input logic [7:0] c);
      logic [7:0] cp;
      cp = c;
      case (lead)
         LEAD_D0: begin
            if (c == D0_YO_IN) begin
               cp = CP_YO_UPPER;
            end else if (c inside {[8'h90:8'hBF]}) begin
               cp = c + D0_OFFSET;
            end
         end
         LEAD_D1: begin
            if (c == D1_YO_IN) begin
               cp = CP_YO_LOWER;
            end else if (c inside {[8'h80:8'h8F]}) begin
               cp = c + D1_OFFSET;
            end
         end
         default: begin
            cp = c;
         end
      endcase
      return cp;
   endfunction

endpackage

### rtl/cyrlcd_if.sv
// cyrlcd channel interfaces: request, response and register write channels
// depends on cyrlcd_pkg for the payload types
interface cyrlcd_req_if;
   import cyrlcd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cyrlcd_rsp_if;
   import cyrlcd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cyrlcd_csr_if;
   import cyrlcd_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/cyrillic_utf8_to_lcd_rom_transcoder_unit.sv
// top level of the cyrillic text transcoder: utf-8 fold, cp1251 to rom lookup
// depends on cyrlcd_pkg and the channel interfaces in cyrlcd_if.sv
//
//  channel  | direction | payload                       | handshake
//  req_if   | in        | in_byte[7:0], end_of_string   | valid / ready
//  rsp_if   | out       | display_code[7:0], last_code  | valid / ready
//  csr_if   | in        | utf8_mode                     | valid / ready (always ready)
//
// one request per cycle sustained while responses are taken; input register then
// result register, decode and rom lookup in between.
// in utf-8 mode a lead byte or a decoded zero consumes its request without a response.
// a stalled response holds the result register and the input register
// behind it; ready drops only when both are full and the response is stalled.
// synchronous reset clears the valid flags, the held lead and sets utf8 mode.
module cyrillic_utf8_to_lcd_rom_transcoder_unit (
   input  logic              clock,
   input  logic              reset,
   cyrlcd_req_if.sink        req_if,
   cyrlcd_rsp_if.source      rsp_if,
   cyrlcd_csr_if.sink        csr_if
);
   import cyrlcd_pkg::*;

   logic            utf8_mode_ff;
   lead_type        lead_ff, lead_in;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            advance;
   logic            has_result;
   logic [7:0]      cp_byte;

   assign csr_if.ready = 1'b1;

   // result register free or being emptied this cycle
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_mode_ff <= 1'b1;
      end else if (csr_if.valid) begin
         utf8_mode_ff <= csr_if.payload.utf8_mode;
      end
   end

   always_comb begin
      lead_in    = lead_ff;
      has_result = 1'b0;
      cp_byte    = in_data_ff.in_byte;
      if (!utf8_mode_ff) begin
         lead_in    = LEAD_NONE;
         has_result = 1'b1;
      end else if (lead_ff != LEAD_NONE) begin
         cp_byte    = fold_second(lead_ff, in_data_ff.in_byte);
         lead_in    = LEAD_NONE;
         has_result = (cp_byte != 8'h00);
      end else if (in_data_ff.in_byte == LEAD_BYTE_D0 || in_data_ff.in_byte == LEAD_BYTE_D1) begin
         // a lead marked last is dropped outright
         if (in_data_ff.end_of_string) begin
            lead_in = LEAD_NONE;
         end else if (in_data_ff.in_byte == LEAD_BYTE_D0) begin
            lead_in = LEAD_D0;
         end else begin
            lead_in = LEAD_D1;
         end
      end else begin
         lead_in    = LEAD_NONE;
         has_result = (cp_byte != 8'h00);
      end
      out_data_in.display_code = to_rom(cp_byte);
      out_data_in.last_code    = in_data_ff.end_of_string;
      out_valid_in             = in_valid_ff && has_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lead_ff      <= LEAD_NONE;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            out_valid_ff <= out_valid_in;
            if (in_valid_ff) begin
               lead_ff <= lead_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_data_ff <= req_if.payload;
      end
      if (advance && out_valid_in) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

### tb/rom_code_checker.sv
// rom_code_checker: watches the request, response and register channels of the
// cyrillic transcoder, predicts each display code and compares it in order
// depends on cyrlcd_pkg and the channel interfaces in cyrlcd_if.sv
module rom_code_checker (
   input  logic        clock,
   input  logic        reset,
   cyrlcd_req_if       req_if,
   cyrlcd_rsp_if       rsp_if,
   cyrlcd_csr_if       csr_if,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import cyrlcd_pkg::*;

   localparam logic [7:0] UPPER_SECOND_LO = 8'h90;
   localparam logic [7:0] UPPER_SECOND_HI = 8'hBF;
   localparam logic [7:0] UPPER_SHIFT     = 8'h30;
   localparam logic [7:0] LOWER_SECOND_LO = 8'h80;
   localparam logic [7:0] LOWER_SECOND_HI = 8'h8F;
   localparam logic [7:0] LOWER_SHIFT     = 8'h70;
   localparam logic [7:0] FIRST_LETTER    = 8'hC0;
   localparam logic [7:0] GLYPH_YO_UPPER  = 8'hA2;
   localparam logic [7:0] GLYPH_YO_LOWER  = 8'hB5;
   localparam int unsigned REPORT_LIMIT   = 10;

   // glyph codes for cp1251 letters 0xc0..0xff
   localparam logic [7:0] GLYPH_TABLE [64] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   logic            utf8_on;
   lead_type        lead_held;
   rsp_payload_type expected_codes [$];
   rsp_payload_type seen;
   rsp_payload_type wanted;

   function automatic logic [7:0] glyph_of(input logic [7:0] cp);
      if (cp >= FIRST_LETTER) begin
         return GLYPH_TABLE[cp[5:0]];
      end
      if (cp == CP_YO_UPPER) begin
         return GLYPH_YO_UPPER;
      end
      if (cp == CP_YO_LOWER) begin
         return GLYPH_YO_LOWER;
      end
      return cp;
   endfunction

   task automatic predict_code(input req_payload_type r);
      logic [7:0] cp;
      logic       emits;
      cp    = r.in_byte;
      emits = 1'b1;
      if (!utf8_on) begin
         // plain cp1251 also drops any lead left from utf-8 mode
         lead_held = LEAD_NONE;
      end else if (lead_held == LEAD_D0) begin
         if (r.in_byte == D0_YO_IN) begin
            cp = CP_YO_UPPER;
         end else if (r.in_byte >= UPPER_SECOND_LO && r.in_byte <= UPPER_SECOND_HI) begin
            cp = r.in_byte + UPPER_SHIFT;
         end
         lead_held = LEAD_NONE;
      end else if (lead_held == LEAD_D1) begin
         if (r.in_byte == D1_YO_IN) begin
            cp = CP_YO_LOWER;
         end else if (r.in_byte >= LOWER_SECOND_LO && r.in_byte <= LOWER_SECOND_HI) begin
            cp = r.in_byte + LOWER_SHIFT;
         end
         lead_held = LEAD_NONE;
      end else if (r.in_byte == LEAD_BYTE_D0 || r.in_byte == LEAD_BYTE_D1) begin
         emits = 1'b0;
         // a lead marked last is thrown away
         if (!r.end_of_string) begin
            lead_held = (r.in_byte == LEAD_BYTE_D0) ? LEAD_D0 : LEAD_D1;
         end
      end
      // a decoded zero is swallowed in utf-8 mode only
      if (emits && (cp != 8'h00 || !utf8_on)) begin
         expected_codes.push_back('{display_code: glyph_of(cp),
                                    last_code: r.end_of_string});
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t mismatch, %s: expected code %h last %b, got code %h last %b",
                  $realtime, what, wanted.display_code, wanted.last_code,
                  seen.display_code, seen.last_code);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         utf8_on   = 1'b1;
         lead_held = LEAD_NONE;
         expected_codes.delete();
         mismatches = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            utf8_on = csr_if.payload.utf8_mode;
         end
         if (req_if.valid && req_if.ready) begin
            predict_code(req_if.payload);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen = rsp_if.payload;
            if (expected_codes.size() == 0) begin
               wanted = '0;
               note_mismatch("response with no request pending");
            end else begin
               wanted = expected_codes.pop_front();
               if (seen.display_code != wanted.display_code ||
                   seen.last_code != wanted.last_code) begin
                  note_mismatch("wrong response");
               end
            end
         end
      end
      outstanding = unsigned'(expected_codes.size());
   end

endmodule

### tb/tb.sv
// tb: clock, reset and stimulus for the cyrillic transcoder, with the verdict
// depends on cyrlcd_pkg, cyrlcd_if.sv, the transcoder rtl and rom_code_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cyrlcd_pkg::*;

   localparam logic [7:0] UPPER_SECOND_LO = 8'h90;
   localparam logic [7:0] UPPER_SECOND_HI = 8'hBF;
   localparam logic [7:0] LOWER_SECOND_LO = 8'h80;
   localparam logic [7:0] LOWER_SECOND_HI = 8'h8F;
   localparam int unsigned PHASE_LENGTH   = 220;
   localparam int unsigned LONG_HOLD      = 80;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned sent_count;
   bit          idling_on    = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned hold_left;
   int unsigned stall_left;

   cyrlcd_req_if req_ch ();
   cyrlcd_rsp_if rsp_ch ();
   cyrlcd_csr_if csr_ch ();

   cyrillic_utf8_to_lcd_rom_transcoder_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   rom_code_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_if      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on demand
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left   = $urandom_range(0, 8);
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic logic random_end();
      return ($urandom_range(0, 7) == 0);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid                 = 1'b1;
      req_ch.payload.in_byte       = b;
      req_ch.payload.end_of_string = eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // wait for every response, then for a lead or zero still in the pipe
   task automatic drain();
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic utf8);
      drain();
      csr_ch.valid             = 1'b1;
      csr_ch.payload.utf8_mode = utf8;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic send_text(input logic utf8);
      int unsigned pick;
      logic [7:0]  second;
      pick = $urandom_range(0, 99);
      if (!utf8) begin
         if (pick < 60) begin
            send_byte(8'($urandom_range(8'hC0, 8'hFF)), random_end());
         end else begin
            send_byte(8'($urandom), random_end());
         end
      end else if (pick < 33) begin
         second = ($urandom_range(0, 15) == 0) ? D0_YO_IN :
                  8'($urandom_range(UPPER_SECOND_LO, UPPER_SECOND_HI));
         send_byte(LEAD_BYTE_D0, 1'b0);
         send_byte(second, random_end());
      end else if (pick < 65) begin
         second = ($urandom_range(0, 15) == 0) ? D1_YO_IN :
                  8'($urandom_range(LOWER_SECOND_LO, LOWER_SECOND_HI));
         send_byte(LEAD_BYTE_D1, 1'b0);
         send_byte(second, random_end());
      end else if (pick < 78) begin
         send_byte(8'($urandom_range(8'h20, 8'h7F)), random_end());
      end else if (pick < 88) begin
         // broken pair: odd second byte, or a lead cut off at string end
         send_byte($urandom_range(0, 1) ? LEAD_BYTE_D0 : LEAD_BYTE_D1,
                   $urandom_range(0, 3) == 0);
         send_byte(8'($urandom), random_end());
      end else begin
         send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int unsigned target;
      logic        mode;
      reset                        = 1'b1;
      req_ch.valid                 = 1'b0;
      req_ch.payload               = '0;
      csr_ch.valid                 = 1'b0;
      csr_ch.payload               = '0;
      sent_count                   = 0;
      repeat (3) @(negedge clock);
      reset     = 1'b0;
      idling_on = 1'b1;

      // utf-8 mode out of reset
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(UPPER_SECOND_LO, 1'b0);
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(UPPER_SECOND_HI, 1'b1);
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(D0_YO_IN, 1'b0);
      send_byte(LEAD_BYTE_D1, 1'b0);
      send_byte(LOWER_SECOND_LO, 1'b0);
      send_byte(LEAD_BYTE_D1, 1'b0);
      send_byte(LOWER_SECOND_HI, 1'b1);
      send_byte(LEAD_BYTE_D1, 1'b0);
      send_byte(D1_YO_IN, 1'b0);
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(LEAD_BYTE_D1, 1'b1);
      send_byte(8'h80, 1'b0);
      // lead carried over into the next string
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(LEAD_BYTE_D1, 1'b0);
      send_byte(LEAD_BYTE_D0, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CP_YO_UPPER, 1'b1);
      // lead left held across the switch to cp1251
      send_byte(LEAD_BYTE_D0, 1'b0);
      write_mode(1'b0);
      send_byte(LEAD_BYTE_D0, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(CP_YO_LOWER, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         mode = (phase == 1 || phase == 4) ? 1'b0 : 1'b1;
         write_mode(mode);
         idling_on = (phase != 5);
         if (phase == 2) begin
            // long response hold-off while requests keep coming
            idling_on    = 1'b0;
            hold_request = 1'b1;
            repeat (30) send_text(mode);
            drain();
            idling_on = 1'b1;
         end
         target = sent_count + PHASE_LENGTH;
         while (sent_count < target) begin
            if (phase != 5 && $urandom_range(0, 49) == 0) begin
               idling_on = !idling_on;
            end
            send_text(mode);
         end
      end

      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/cyrlcd_pkg.sv
rtl/cyrlcd_if.sv
rtl/cyrillic_utf8_to_lcd_rom_transcoder_unit.sv
tb/rom_code_checker.sv
tb/tb.sv
